// ===== hw/rtl/xfrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfrp_pkg
// Shared types and constants for the XOR-checked frame receive parser.
// ----------------------------------------------------------------------------
package xfrp_pkg;

  localparam logic [7:0] START_BYTE = 8'hBD;
  localparam logic [7:0] MIN_LENGTH = 8'd3;
  // The command and status bytes are counted by the length but are not body.
  localparam logic [7:0] HEADER_COUNT = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_CMD    = 3'd2,
    PH_STATUS = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_OK      = 3'd1,
    KIND_CSUM    = 3'd2,
    KIND_START   = 3'd3,
    KIND_LENGTH  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_command;
    logic [7:0] frame_status;
    logic       frame_end;
  } result_t;

endpackage

// ===== hw/rtl/xfrp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfrp_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module xfrp_in_stage import xfrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       consume,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // A new byte may enter when the register is empty or is being drained.
  assign in_stall  = valid_r && !consume;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

// ===== hw/rtl/xfrp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfrp_core
// Frame state machine, running XOR and result formation for one byte.
// ----------------------------------------------------------------------------
module xfrp_core import xfrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] xor_sum;

  assign xor_sum = xor_r ^ rx_byte;

  always_comb begin
    phase_nxt  = phase_r;
    xor_nxt    = xor_sum;
    left_nxt   = left_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    res_valid  = 1'b0;
    res        = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, frame_command: 8'd0,
                   frame_status: 8'd0, frame_end: 1'b0};
    case (phase_r)
      PH_LENGTH: begin
        if (rx_byte < MIN_LENGTH) begin
          phase_nxt      = PH_IDLE;
          res_valid      = 1'b1;
          res.kind       = KIND_LENGTH;
          res.frame_end  = 1'b1;
        end else begin
          left_nxt  = rx_byte - HEADER_COUNT;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        phase_nxt = PH_STATUS;
      end
      PH_STATUS: begin
        status_nxt = rx_byte;
        phase_nxt  = PH_BODY;
      end
      PH_BODY: begin
        res_valid         = 1'b1;
        res.frame_command = cmd_r;
        res.frame_status  = status_r;
        if (left_r > 8'd1) begin
          left_nxt         = left_r - 8'd1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end else begin
          // Checksum byte: the whole frame must XOR to zero.
          left_nxt      = 8'd0;
          phase_nxt     = PH_IDLE;
          res.kind      = (xor_sum == 8'd0) ? KIND_OK : KIND_CSUM;
          res.frame_end = 1'b1;
        end
      end
      default: begin
        xor_nxt = rx_byte;
        if (rx_byte != START_BYTE) begin
          phase_nxt     = PH_IDLE;
          res_valid     = 1'b1;
          res.kind      = KIND_START;
          res.frame_end = 1'b1;
        end else begin
          phase_nxt = PH_LENGTH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      xor_r    <= 8'd0;
      left_r   <= 8'd0;
      cmd_r    <= 8'd0;
      status_r <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      xor_r    <= xor_nxt;
      left_r   <= left_nxt;
      cmd_r    <= cmd_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== hw/rtl/xor_frame_receive_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_frame_receive_parser
// Parses XOR-checked reply frames from a received byte stream.
// ----------------------------------------------------------------------------
// Usage: received bytes arrive on the in_ channel, one byte per transfer.
// Frames are 0xBD, length, command, status, payload bytes and a checksum.
// Each payload byte is passed out on the out_ channel; the checksum byte
// gives a frame-end result saying whether the frame XOR came to zero.
// A wrong start byte or a length below 3 gives an error result at once.
// Header bytes give no result.
// A result passes from the input register through the parse logic into
// the result register. Throughput is one byte per cycle while the
// receiver does not stall, set by the combinational parse step between
// the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle with a cleared XOR. When the receiver stalls, the result
// register holds; the input register still takes one more byte, after
// which in_stall rises until the result is transferred.
// ----------------------------------------------------------------------------
module xor_frame_receive_parser import xfrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_frame_command,
  output logic [7:0] out_frame_status,
  output logic       out_frame_end
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = hold_valid && out_free;

  xfrp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .consume   (step),
    .hold_valid(hold_valid),
    .hold_byte (hold_byte)
  );

  xfrp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (hold_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_frame_command = out_r.frame_command;
  assign out_frame_status  = out_r.frame_status;
  assign out_frame_end     = out_r.frame_end;

endmodule
